### design/fubt_pkg.sv
// Shared types and constants for the first unique byte tracker.
// No dependencies; every other design file imports this package.
package fubt_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int BYTE_W        = 8;
  localparam int IDX_W         = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int LEN_W         = $clog2(ALPHABET_SIZE + 1);
  localparam int CNT_W         = 2;

  localparam logic [BYTE_W:0] ALPHA_LIM = (BYTE_W + 1)'(ALPHABET_SIZE);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    MARK_NONE     = 2'b00,
    MARK_LISTED   = 2'b01,
    MARK_REPEATED = 2'b10
  } mark_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } rd_req_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    mark_t data;
  } mark_wr_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    byte_t data;
  } link_wr_t;

  function automatic idx_t to_idx(byte_t b);
    return b[IDX_W-1:0];
  endfunction

endpackage

### design/fubt_in_if.sv
// Input channel of the tracker: one stream byte per word.
// Depends on fubt_pkg.
interface fubt_in_if import fubt_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t byte_value;
  logic  new_stream;

  modport source (output valid, output byte_value, output new_stream, input ready);
  modport sink   (input valid, input byte_value, input new_stream, output ready);
endinterface

### design/fubt_out_if.sv
// Output channel of the tracker: the first three unique bytes per word.
// Depends on fubt_pkg.
interface fubt_out_if import fubt_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t first_unique;
  byte_t second_unique;
  byte_t third_unique;
  cnt_t  unique_count;

  modport source (output valid, output first_unique, output second_unique,
                  output third_unique, output unique_count, input ready);
  modport sink   (input valid, input first_unique, input second_unique,
                  input third_unique, input unique_count, output ready);
endinterface

### design/fubt_mark_store.sv
// Per-byte mark memory (listed / repeated) with one read and one write port.
// Valid bits give the cleared value after reset or a new stream. Depends on fubt_pkg.
module fubt_mark_store import fubt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     clr,
  input  rd_req_t  rd,
  input  mark_wr_t wr,
  output mark_t    rd_data
);

  mark_t                    mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] valid;
  mark_t                    mem_q;
  mark_t                    fwd_data;
  logic                     fwd_hit;
  logic                     valid_hit;
  logic                     clr_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mem_q <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      fwd_hit   <= wr.en && (wr.addr == rd.addr);
      fwd_data  <= wr.data;
      valid_hit <= valid[rd.addr];
      clr_hit   <= clr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clr) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_comb begin
    priority if (clr_hit) begin
      rd_data = MARK_NONE;
    end else if (fwd_hit) begin
      rd_data = fwd_data;
    end else if (valid_hit) begin
      rd_data = mem_q;
    end else begin
      rd_data = MARK_NONE;
    end
  end

endmodule

### design/fubt_link_store.sv
// Next and previous link memories of the list, indexed by byte value.
// Write-through forwarding on every read port. Depends on fubt_pkg.
module fubt_link_store import fubt_pkg::*; (
  input  logic     clk,
  input  rd_req_t  rd_v,
  input  rd_req_t  rd_s,
  input  link_wr_t next_wr,
  input  link_wr_t prev_wr,
  output byte_t    next_v,
  output byte_t    next_s,
  output byte_t    prev_v
);

  byte_t next_mem [ALPHABET_SIZE];
  byte_t prev_mem [ALPHABET_SIZE];
  byte_t next_v_q;
  byte_t next_s_q;
  byte_t prev_v_q;
  byte_t next_fwd;
  byte_t prev_fwd;
  logic  nv_hit;
  logic  ns_hit;
  logic  pv_hit;

  always_ff @(posedge clk) begin
    if (next_wr.en) begin
      next_mem[next_wr.addr] <= next_wr.data;
    end
    if (rd_v.en) begin
      next_v_q <= next_mem[rd_v.addr];
    end
    if (rd_s.en) begin
      next_s_q <= next_mem[rd_s.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_wr.en) begin
      prev_mem[prev_wr.addr] <= prev_wr.data;
    end
    if (rd_v.en) begin
      prev_v_q <= prev_mem[rd_v.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v.en) begin
      nv_hit   <= next_wr.en && (next_wr.addr == rd_v.addr);
      pv_hit   <= prev_wr.en && (prev_wr.addr == rd_v.addr);
      prev_fwd <= prev_wr.data;
    end
    if (rd_s.en) begin
      ns_hit <= next_wr.en && (next_wr.addr == rd_s.addr);
    end
    if (rd_v.en || rd_s.en) begin
      next_fwd <= next_wr.data;
    end
  end

  assign next_v = nv_hit ? next_fwd : next_v_q;
  assign next_s = ns_hit ? next_fwd : next_s_q;
  assign prev_v = pv_hit ? prev_fwd : prev_v_q;

endmodule

### design/fubt_list_core.sv
// List update stage: head slots, tail, length, link and mark write-back,
// and the result payload register. Depends on fubt_pkg.
module fubt_list_core import fubt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  byte_t    in_byte,
  input  logic     in_new,
  input  logic     advance,
  input  mark_t    mark,
  input  byte_t    nxt,
  input  byte_t    prv,
  input  byte_t    fourth,
  output logic     busy,
  output mark_wr_t mark_wr,
  output link_wr_t next_wr,
  output link_wr_t prev_wr,
  output byte_t    s2_upcoming,
  output byte_t    first_unique,
  output byte_t    second_unique,
  output byte_t    third_unique,
  output cnt_t     unique_count
);

  logic  p1_valid;
  byte_t p1_byte;
  logic  p1_new;

  byte_t s0, s1, s2, tail;
  len_t  len;
  byte_t s0_next, s1_next, s2_next, tail_next;
  len_t  len_next;
  byte_t b_s0, b_s1, b_s2, b_tail;
  len_t  b_len;
  logic  in_range;
  logic  do_append;
  logic  do_unlink;
  logic  is_head;
  logic  is_tail;
  cnt_t  cnt_next;

  assign busy = p1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (advance) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_byte <= in_byte;
      p1_new  <= in_new;
    end
  end

  always_comb begin
    if (p1_new) begin
      b_s0   = '0;
      b_s1   = '0;
      b_s2   = '0;
      b_tail = '0;
      b_len  = '0;
    end else begin
      b_s0   = s0;
      b_s1   = s1;
      b_s2   = s2;
      b_tail = tail;
      b_len  = len;
    end
  end

  assign in_range = ({1'b0, p1_byte} < ALPHA_LIM);
  assign is_head  = (p1_byte == b_s0);
  assign is_tail  = (p1_byte == b_tail);

  always_comb begin
    do_append = 1'b0;
    do_unlink = 1'b0;
    if (in_range) begin
      unique case (mark)
        MARK_NONE:     do_append = 1'b1;
        MARK_LISTED:   do_unlink = 1'b1;
        MARK_REPEATED: do_append = 1'b0;
        default:       do_append = 1'b0;
      endcase
    end
  end

  always_comb begin
    s0_next   = b_s0;
    s1_next   = b_s1;
    s2_next   = b_s2;
    tail_next = b_tail;
    len_next  = b_len;
    next_wr   = '{en: 1'b0, addr: to_idx(b_tail), data: p1_byte};
    prev_wr   = '{en: 1'b0, addr: to_idx(p1_byte), data: b_tail};
    mark_wr   = '{en: advance && (do_append || do_unlink), addr: to_idx(p1_byte),
                  data: do_append ? MARK_LISTED : MARK_REPEATED};
    if (do_append) begin
      len_next  = b_len + len_t'(1);
      tail_next = p1_byte;
      priority if (b_len == len_t'(0)) begin
        s0_next = p1_byte;
      end else begin
        next_wr.en = advance;
        prev_wr.en = advance;
        if (b_len == len_t'(1)) begin
          s1_next = p1_byte;
        end
        if (b_len == len_t'(2)) begin
          s2_next = p1_byte;
        end
      end
    end else if (do_unlink) begin
      len_next = b_len - len_t'(1);
      priority if (is_head && is_tail) begin
        tail_next = '0;
      end else if (is_tail) begin
        tail_next = prv;
      end else if (!is_head) begin
        next_wr = '{en: advance, addr: to_idx(prv), data: nxt};
        prev_wr = '{en: advance, addr: to_idx(nxt), data: prv};
      end else begin
        tail_next = b_tail;
      end
      priority if (is_head) begin
        s0_next = b_s1;
        s1_next = b_s2;
        s2_next = fourth;
      end else if (p1_byte == b_s1) begin
        s1_next = b_s2;
        s2_next = fourth;
      end else if (p1_byte == b_s2) begin
        s2_next = fourth;
      end else begin
        s2_next = b_s2;
      end
    end
  end

  assign s2_upcoming = advance ? s2_next : s2;
  assign cnt_next    = (len_next >= len_t'(3)) ? cnt_t'(3) : cnt_t'(len_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      tail <= '0;
      s0   <= '0;
      s1   <= '0;
      s2   <= '0;
    end else if (advance) begin
      len  <= len_next;
      tail <= tail_next;
      s0   <= s0_next;
      s1   <= s1_next;
      s2   <= s2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      first_unique  <= (cnt_next >= cnt_t'(1)) ? s0_next : '0;
      second_unique <= (cnt_next >= cnt_t'(2)) ? s1_next : '0;
      third_unique  <= (cnt_next == cnt_t'(3)) ? s2_next : '0;
      unique_count  <= cnt_next;
    end
  end

endmodule

### design/first_unique_byte_tracker_unit.sv
// Takes one byte per word and reports, per byte, the three oldest bytes seen exactly
// once so far in the current stream, with how many of them are valid. It sustains one
// byte per cycle unless the report stalls; each byte passes the read stage, then the
// output register. The read-modify-write loop through the mark and link memories
// (read stage, then update and write-back stage) sets the rate, with the single
// write in flight forwarded to the next byte's reads. A new-stream word clears all
// marks at once through valid bits, so there is no clearing pass after reset.
// Depends on fubt_pkg, fubt_in_if, fubt_out_if, fubt_mark_store, fubt_link_store,
// fubt_list_core.
module first_unique_byte_tracker_unit import fubt_pkg::*; (
  input logic        clk,
  input logic        rst,
  fubt_in_if.sink    byte_stream,
  fubt_out_if.source report
);

  logic     out_valid;
  logic     out_free;
  logic     accept;
  logic     advance;
  logic     busy;
  rd_req_t  rd_v;
  rd_req_t  rd_s;
  mark_wr_t mark_wr;
  link_wr_t next_wr;
  link_wr_t prev_wr;
  mark_t    mark;
  byte_t    nxt;
  byte_t    prv;
  byte_t    fourth;
  byte_t    s2_upcoming;

  assign out_free          = !out_valid || report.ready;
  assign advance           = busy && out_free;
  assign byte_stream.ready = !rst && (!busy || out_free);
  assign accept            = byte_stream.valid && byte_stream.ready;

  assign rd_v = '{en: accept, addr: to_idx(byte_stream.byte_value)};
  assign rd_s = '{en: accept, addr: to_idx(s2_upcoming)};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign report.valid = out_valid;

  fubt_mark_store u_marks (
    .clk     (clk),
    .rst     (rst),
    .clr     (accept && byte_stream.new_stream),
    .rd      (rd_v),
    .wr      (mark_wr),
    .rd_data (mark)
  );

  fubt_link_store u_links (
    .clk     (clk),
    .rd_v    (rd_v),
    .rd_s    (rd_s),
    .next_wr (next_wr),
    .prev_wr (prev_wr),
    .next_v  (nxt),
    .next_s  (fourth),
    .prev_v  (prv)
  );

  fubt_list_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (byte_stream.byte_value),
    .in_new        (byte_stream.new_stream),
    .advance       (advance),
    .mark          (mark),
    .nxt           (nxt),
    .prv           (prv),
    .fourth        (fourth),
    .busy          (busy),
    .mark_wr       (mark_wr),
    .next_wr       (next_wr),
    .prev_wr       (prev_wr),
    .s2_upcoming   (s2_upcoming),
    .first_unique  (report.first_unique),
    .second_unique (report.second_unique),
    .third_unique  (report.third_unique),
    .unique_count  (report.unique_count)
  );

endmodule

### design/fubt_checker.sv
// Port-level checks for first_unique_byte_tracker_unit, attached by bind.
// Depends on fubt_pkg and the top level.
module fubt_checker import fubt_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input byte_t first_unique,
  input byte_t second_unique,
  input byte_t third_unique,
  input cnt_t  unique_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable({first_unique, second_unique, third_unique, unique_count}))
    else $error("result word changed while stalled");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without an output stall");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word without an accepted byte");

endmodule

bind first_unique_byte_tracker_unit fubt_checker u_fubt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (byte_stream.valid),
  .in_ready      (byte_stream.ready),
  .out_valid     (report.valid),
  .out_ready     (report.ready),
  .first_unique  (report.first_unique),
  .second_unique (report.second_unique),
  .third_unique  (report.third_unique),
  .unique_count  (report.unique_count)
);
